### rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared widths, character codes and controller/datapath interface types
// for the integer to ascii converter
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int MAX_DIGITS_DEF = 32;

    localparam int WORD_W    = 32;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;
    localparam int CHAR_W    = 8;
    localparam int BIT_CNT_W = $clog2(WORD_W);

    localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    // controller to datapath
    typedef struct packed {
        logic load_in;     // latch magnitude and radix, empty the stack
        logic div_step;    // one restoring division step
        logic push;        // push remainder, start next digit
        logic pop;         // read top of stack into read register
        logic load_sign;   // put '-' into output register
        logic load_digit;  // put popped digit into output register
    } itoa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic neg;          // latched number is negative
        logic more_digits;  // quotient nonzero and stack has room
        logic count_zero;   // stack empty
        logic out_free;     // output register can take a character
    } itoa_sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        unique case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            4'hf: c = 8'h66;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

endpackage

### rtl/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// sequencer for sign output, bit-serial division per digit and stack drain
// ----------------------------------------------------------------------------
module itoa_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  itoa_pkg::itoa_sts_t sts,
    output itoa_pkg::itoa_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SIGN = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_PUSH = 6'b001000,
        ST_RD   = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [itoa_pkg::BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = '0;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                // sign flag is valid in the cycle after load
                if (!sts.neg)
                begin
                    state_next = ST_DIV;
                end
                else if (sts.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                bit_cnt_next = bit_cnt_reg + itoa_pkg::BIT_CNT_W'(1);
                if (bit_cnt_reg == itoa_pkg::BIT_CNT_W'(itoa_pkg::WORD_W - 1))
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = sts.more_digits ? ST_DIV : ST_RD;
            end
            ST_RD:
            begin
                cmd.pop    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    state_next     = sts.count_zero ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

endmodule

### rtl/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// magnitude and radix latch, restoring divider, digit stack, output register
// ----------------------------------------------------------------------------
module itoa_dp
#(
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [itoa_pkg::WORD_W-1:0]         value,
    input  logic                                signed_mode,
    input  logic [itoa_pkg::RADIX_W-1:0]        radix,
    input  logic                                out_stall,
    output logic                                out_valid,
    output logic [itoa_pkg::CHAR_W-1:0]         character,
    output logic                                last_char,
    input  itoa_pkg::itoa_cmd_t                 cmd,
    output itoa_pkg::itoa_sts_t                 sts
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = $clog2(MAX_DIGITS);

    logic [itoa_pkg::WORD_W-1:0]  quo_reg;
    logic [itoa_pkg::DIGIT_W-1:0] rem_reg;
    logic [itoa_pkg::RADIX_W-1:0] radix_reg;
    logic                         neg_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [itoa_pkg::DIGIT_W-1:0] rd_data_reg;
    logic                         out_valid_reg;
    logic [itoa_pkg::CHAR_W-1:0]  char_reg;
    logic                         last_reg;

    logic [itoa_pkg::DIGIT_W-1:0] digit_stack_mem [MAX_DIGITS];

    logic                         in_neg;
    logic [itoa_pkg::WORD_W-1:0]  in_mag;
    logic [itoa_pkg::RADIX_W-1:0] radix_clamped;
    logic [itoa_pkg::RADIX_W-1:0] rem_shift;
    logic [itoa_pkg::RADIX_W-1:0] rem_diff;
    logic                         rem_ge;
    logic [CNT_W-1:0]             count_inc;
    logic [CNT_W-1:0]             count_dec;

    assign in_neg = signed_mode && value[itoa_pkg::WORD_W-1];
    assign in_mag = in_neg ? (~value + itoa_pkg::WORD_W'(1)) : value;

    always_comb
    begin
        priority if (radix < itoa_pkg::RADIX_MIN)
            radix_clamped = itoa_pkg::RADIX_MIN;
        else if (radix > itoa_pkg::RADIX_MAX)
            radix_clamped = itoa_pkg::RADIX_MAX;
        else
            radix_clamped = radix;
    end

    // restoring step: bring down next quotient bit
    assign rem_shift = {rem_reg, quo_reg[itoa_pkg::WORD_W-1]};
    assign rem_ge    = (rem_shift >= radix_reg);
    assign rem_diff  = rem_shift - radix_reg;

    assign count_inc = count_reg + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load_in)
            count_next = '0;
        else if (cmd.push)
            count_next = count_inc;
        else if (cmd.pop)
            count_next = count_dec;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load_sign || cmd.load_digit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            quo_reg   <= in_mag;
            rem_reg   <= '0;
            radix_reg <= radix_clamped;
            neg_reg   <= in_neg;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[itoa_pkg::WORD_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[itoa_pkg::DIGIT_W-1:0]
                              : rem_shift[itoa_pkg::DIGIT_W-1:0];
        end
        else if (cmd.push)
        begin
            rem_reg <= '0;
        end

        if (cmd.load_sign)
        begin
            char_reg <= itoa_pkg::CHAR_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            char_reg <= itoa_pkg::digit_char(rd_data_reg);
            last_reg <= (count_reg == '0);
        end
    end

    // digit stack, one access per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            digit_stack_mem[count_reg[IDX_W-1:0]] <= rem_reg;
        if (cmd.pop)
            rd_data_reg <= digit_stack_mem[count_dec[IDX_W-1:0]];
    end

    assign sts.neg         = neg_reg;
    assign sts.more_digits = (quo_reg != '0) && (count_inc < CNT_W'(MAX_DIGITS));
    assign sts.count_zero  = (count_reg == '0);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last_char = last_reg;

endmodule

### rtl/integer_to_ascii_radix_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// converts a 32-bit number to lower-case ascii digits in radix 2 to 16
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  in       sink       in_valid / in_stall  value[31:0] signed_mode radix[4:0]
//  out      source     out_valid/out_stall  character[7:0] last_char
//
//  steps: each request runs the sign step, then per digit the restoring
//    divider at one bit per cycle and one push, then pops and presents
//    each digit in turn (worst case 32 digits)
//  reset: rst_n clears controller state, digit count and output valid;
//    the digit stack holds no reset value and is only read where written
//  stalls: out_stall only holds the sign or emit step; a new request is
//    taken once the previous one has handed its last character to the
//    output register, even while that character still waits
//
module integer_to_ascii_radix_top
#(
    parameter int MAX_DIGITS = itoa_pkg::MAX_DIGITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    // request in
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [itoa_pkg::WORD_W-1:0]  value,
    input  logic                         signed_mode,
    input  logic [itoa_pkg::RADIX_W-1:0] radix,

    // characters out
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [itoa_pkg::CHAR_W-1:0]  character,
    output logic                         last_char
);

    // command and status between sequencer and datapath
    itoa_pkg::itoa_cmd_t cmd;
    itoa_pkg::itoa_sts_t sts;

    // sequencer: sign, division loop per digit, stack drain
    itoa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: divider, digit stack and output register
    itoa_dp
    #(
        .MAX_DIGITS (MAX_DIGITS)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .signed_mode (signed_mode),
        .radix       (radix),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .character   (character),
        .last_char   (last_char),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef NO_ASSERTIONS
    // an accepted request blocks the input until its work is done
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall
    ) else $error("input not blocked after accepting a request");

    // the minus sign never ends a run
    a_minus_not_last: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && character == itoa_pkg::CHAR_MINUS) |-> !last_char
    ) else $error("minus sign marked as last character");

    // never pop an empty digit stack
    a_no_pop_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !sts.count_zero
    ) else $error("pop from empty digit stack");

    // a character is only loaded when the output register can take it
    a_load_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.load_sign || cmd.load_digit) |-> sts.out_free
    ) else $error("output register overwritten");
`endif

endmodule
